// ===== design/text_mode_terminal_writer_defines.svh =====
// Assertion macros for the text-mode terminal writer checker.
// Expects clk and rst in scope where a macro is used.
`ifndef TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH

// Checked only while out of reset.
`define TTW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("terminal writer assertion failed");

// Checked at every edge, reset included.
`define TTW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("terminal writer assertion failed");

`endif

// ===== design/ttw_pkg.sv =====
// Shared types and constants of the text-mode terminal writer.
// No dependencies; used by every module of the block but ttw_ram.
package ttw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 12;
  localparam int CELL_W = 16;
  localparam int CUR_W  = 11;

  localparam logic [7:0]        ATTR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam logic [7:0] TAB_STEP = 8'd8;
  localparam logic [7:0] TAB_MASK = ~8'd7;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_CHAR_ATTRIBUTE = 2'd0;
  localparam cfg_index_t CFG_BLANK_CELL     = 2'd1;

  typedef enum logic [3:0] {
    OP_READ,
    OP_NOP,
    OP_BS,
    OP_HT,
    OP_NL,
    OP_FF,
    OP_CR,
    OP_DEL,
    OP_PRINT
  } op_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic        end_of_write;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  char_code;
    logic        end_of_write;
    logic [10:0] cell_index;
  } cmd_t;

endpackage

// ===== design/ttw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ttw_front.sv =====
// Front end: accepts input words, decodes them into commands and queues them.
// Depends on ttw_pkg.
module ttw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttw_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output ttw_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  ttw_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  ttw_pkg::op_t  op;
  logic          push;

  always_comb begin
    if (in_item.func) begin
      op = ttw_pkg::OP_READ;
    end else begin
      unique case (in_item.char_code) inside
        ttw_pkg::CH_NUL, ttw_pkg::CH_ENQ, ttw_pkg::CH_BEL: op = ttw_pkg::OP_NOP;
        ttw_pkg::CH_BS:                                    op = ttw_pkg::OP_BS;
        ttw_pkg::CH_HT:                                    op = ttw_pkg::OP_HT;
        ttw_pkg::CH_LF, ttw_pkg::CH_VT:                    op = ttw_pkg::OP_NL;
        ttw_pkg::CH_FF:                                    op = ttw_pkg::OP_FF;
        ttw_pkg::CH_CR:                                    op = ttw_pkg::OP_CR;
        ttw_pkg::CH_DEL:                                   op = ttw_pkg::OP_DEL;
        default:                                           op = ttw_pkg::OP_PRINT;
      endcase
    end
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op, char_code: in_item.char_code,
                         end_of_write: in_item.end_of_write,
                         cell_index: in_item.cell_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// ===== design/ttw_back.sv =====
// Back end: executes commands on the cell RAM, owns cursor, config and result.
// Depends on ttw_pkg and ttw_ram.
module ttw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  ttw_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                cfg_valid,
  input  ttw_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ttw_pkg::out_item_t  out_item
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = ttw_pkg::LIN_W;
  localparam int CW    = ttw_pkg::COL_W;
  localparam int RW    = ttw_pkg::ROW_W;

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST  = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW_0 = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
  localparam logic [LW-1:0] CELLS_L    = LW'(CELLS);
  localparam logic [CW-1:0] COLS_C     = CW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_COPY   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         col, col_next;
  logic [RW-1:0]         row, row_next;
  logic [10:0]           creg, creg_next;
  logic [AW-1:0]         cnt, cnt_next;
  logic                  wv;
  logic [AW-1:0]         wa;
  logic                  eow_p, eow_p_next;
  logic                  print_p, print_p_next;
  logic [7:0]            char_p, char_p_next;
  logic                  rd_ok, rd_ok_next;
  logic                  out_valid_next;
  ttw_pkg::out_item_t    out_item_next;
  logic [7:0]            char_attribute;
  logic [15:0]           blank_cell;

  logic                  issue;
  logic [CW-1:0]         lin_col;
  logic [LW-1:0]         lin_addr;
  logic [LW-1:0]         lin_fin;
  logic [7:0]            ht_col;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [15:0]           wdata;
  logic [AW-1:0]         raddr;
  logic [15:0]           rdata;

  ttw_ram #(.WIDTH(ttw_pkg::CELL_W), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign issue   = (state == S_IDLE) && cmd_valid && (!out_valid || out_ready);
  assign cmd_pop = issue;
  assign lin_col = (state == S_IDLE && cmd.op == ttw_pkg::OP_BS) ? col - 1'b1 : col;
  assign lin_addr = LW'(row) * LW'(COLUMNS) + LW'(lin_col);
  assign lin_fin  = lin_addr + LW'(print_p);
  assign ht_col   = ({1'b0, col} + ttw_pkg::TAB_STEP) & ttw_pkg::TAB_MASK;

  always_comb begin
    logic do_nl;
    do_nl          = 1'b0;
    state_next     = state;
    col_next       = col;
    row_next       = row;
    creg_next      = creg;
    cnt_next       = cnt;
    eow_p_next     = eow_p;
    print_p_next   = print_p;
    char_p_next    = char_p;
    rd_ok_next     = rd_ok;
    out_valid_next = out_valid && !out_ready;
    out_item_next  = out_item;
    we             = 1'b0;
    waddr          = cnt;
    wdata          = blank_cell;
    raddr          = cnt + ROW_STEP;

    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = ttw_pkg::BLANK_RESET;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (issue) begin
          eow_p_next   = cmd.end_of_write;
          char_p_next  = cmd.char_code;
          print_p_next = 1'b0;
          state_next   = S_FINISH;
          unique case (cmd.op)
            ttw_pkg::OP_READ: begin
              raddr      = AW'(cmd.cell_index);
              rd_ok_next = (LW'(cmd.cell_index) < CELLS_L);
              state_next = S_READ;
            end
            ttw_pkg::OP_BS: begin
              if (col != '0) begin
                col_next = col - 1'b1;
                we       = 1'b1;
                waddr    = AW'(lin_addr);
              end
            end
            ttw_pkg::OP_HT: begin
              if (ht_col >= 8'(COLUMNS)) begin
                do_nl = 1'b1;
              end else begin
                col_next = ht_col[CW-1:0];
              end
            end
            ttw_pkg::OP_NL: do_nl = 1'b1;
            ttw_pkg::OP_FF: begin
              row_next   = '0;
              col_next   = '0;
              creg_next  = '0;
              cnt_next   = '0;
              state_next = S_BLANK;
            end
            ttw_pkg::OP_CR: col_next = '0;
            ttw_pkg::OP_DEL: begin
              if (lin_addr < CELLS_L) begin
                we    = 1'b1;
                waddr = AW'(lin_addr);
              end
            end
            ttw_pkg::OP_PRINT: begin
              print_p_next = 1'b1;
              if (col >= COLS_C) begin
                do_nl = 1'b1;
              end
            end
            default: ;
          endcase
          if (do_nl) begin
            col_next = '0;
            if (row == LAST_ROW) begin
              row_next   = LAST_ROW;
              creg_next  = 11'(LW'(LAST_ROW_0));
              cnt_next   = '0;
              state_next = S_COPY;
            end else begin
              row_next = row + 1'b1;
            end
          end
        end
      end
      S_READ: begin
        out_valid_next          = 1'b1;
        out_item_next.cursor_offset = creg;
        out_item_next.cell_data = rd_ok ? rdata : 16'd0;
        state_next              = S_IDLE;
      end
      S_COPY: begin
        if (cnt == COPY_LAST) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_next   = LAST_ROW_0;
        state_next = S_BLANK;
      end
      S_BLANK: begin
        we = 1'b1;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FINISH: begin
        if (print_p) begin
          we       = 1'b1;
          waddr    = AW'(lin_addr);
          wdata    = {char_attribute, char_p};
          col_next = col + 1'b1;
        end
        if (eow_p) begin
          creg_next = lin_fin[10:0];
        end
        out_valid_next              = 1'b1;
        out_item_next.cursor_offset = eow_p ? lin_fin[10:0] : creg;
        out_item_next.cell_data     = 16'd0;
        state_next                  = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase

    if (wv) begin
      we    = 1'b1;
      waddr = wa;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      wv        <= 1'b0;
      col       <= '0;
      row       <= '0;
      creg      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      wv        <= (state == S_COPY);
      col       <= col_next;
      row       <= row_next;
      creg      <= creg_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    wa       <= cnt;
    eow_p    <= eow_p_next;
    print_p  <= print_p_next;
    char_p   <= char_p_next;
    rd_ok    <= rd_ok_next;
    out_item <= out_item_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attribute <= ttw_pkg::ATTR_RESET;
      blank_cell     <= ttw_pkg::BLANK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttw_pkg::CFG_CHAR_ATTRIBUTE: char_attribute <= cfg_data[7:0];
        ttw_pkg::CFG_BLANK_CELL:     blank_cell     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/text_mode_terminal_writer.sv =====
// Top level of the text-mode terminal writer: front decoder, back executor.
// Depends on ttw_pkg, ttw_front, ttw_back (and ttw_ram through ttw_back).
//
// Character-cell console of ROWS x COLUMNS 16-bit cells (attribute high,
// character low) held in one RAM with a single write port, so every cell
// change goes through that port. After reset a clearing pass writes the
// reset blank cell to all ROWS*COLUMNS cells; input words queue up
// meanwhile but none is executed. Reads pass through S_READ and most
// bytes through S_FINISH. Line feed, vertical tab, tab or wrap below the
// last row scroll the screen up one row. Form feed clears the screen. A
// two-word queue sits between decode and execute, and each result waits in
// an output register. The config port is always ready; write it only while
// no word is in flight.
module text_mode_terminal_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttw_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ttw_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ttw_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data
);

  logic          cmd_valid;
  ttw_pkg::cmd_t cmd;
  logic          cmd_pop;

  assign cfg_ready = 1'b1;

  ttw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ttw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== design/ttw_checker.sv =====
// Port-level checker for the text-mode terminal writer, bound to the top level.
// Depends on ttw_pkg and text_mode_terminal_writer_defines.svh.
`include "text_mode_terminal_writer_defines.svh"

module ttw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input ttw_pkg::in_item_t   in_item,
  input logic                out_valid,
  input logic                out_ready,
  input ttw_pkg::out_item_t  out_item,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  localparam int CELLS = ROWS * COLUMNS;

  `TTW_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_item))
  `TTW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))
  `TTW_ASSERT(a_cursor_range, out_valid |-> out_item.cursor_offset <= CELLS)
  `TTW_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)
  `TTW_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid)

endmodule

bind text_mode_terminal_writer ttw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the text-mode terminal writer.
// Drives byte writes and cell reads through a cycle-free model of the
// console; depends on ttw_pkg and the text_mode_terminal_writer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = 80;
  localparam int NROWS = 25;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int SETTLE = 2200;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  ttw_pkg::in_item_t in_item;
  ttw_pkg::out_item_t out_item;
  ttw_pkg::cfg_index_t cfg_index;
  logic [15:0] cfg_data;

  text_mode_terminal_writer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // console model
  logic [15:0] screen_cells [NCELLS];
  int cur_col, cur_row;
  logic [10:0] cursor_reg;
  logic [7:0] attr_byte;
  logic [15:0] blank_word;

  ttw_pkg::out_item_t expected_results [$];
  int mismatches = 0;
  int results_seen = 0;

  typedef struct {
    bit fixed;
    ttw_pkg::in_item_t word;
    ttw_pkg::out_item_t result;
  } dir_row_t;
  dir_row_t directed_rows [$];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void load_cursor();
    cursor_reg = 11'((cur_row * NCOLS + cur_col) & 'h7FF);
  endfunction

  function automatic void new_line();
    if (cur_row + 1 < NROWS) begin
      cur_row++;
      cur_col = 0;
    end else begin
      for (int i = 0; i < NCELLS - NCOLS; i++) screen_cells[i] = screen_cells[i + NCOLS];
      for (int i = NCELLS - NCOLS; i < NCELLS; i++) screen_cells[i] = blank_word;
      cur_row = NROWS - 1;
      cur_col = 0;
      load_cursor();
    end
  endfunction

  function automatic ttw_pkg::out_item_t predict_terminal(ttw_pkg::in_item_t w);
    ttw_pkg::out_item_t r;
    int lin;
    r.cell_data = '0;
    if (w.func) begin
      if (w.cell_index < NCELLS) r.cell_data = screen_cells[w.cell_index];
    end else begin
      case (w.char_code)
        ttw_pkg::CH_NUL, ttw_pkg::CH_ENQ, ttw_pkg::CH_BEL: ;
        ttw_pkg::CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            screen_cells[cur_row * NCOLS + cur_col] = blank_word;
          end
        end
        ttw_pkg::CH_HT: begin
          cur_col = (cur_col + 8) & ~7;
          if (cur_col >= NCOLS) new_line();
        end
        ttw_pkg::CH_LF, ttw_pkg::CH_VT: new_line();
        ttw_pkg::CH_FF: begin
          for (int i = 0; i < NCELLS; i++) screen_cells[i] = blank_word;
          cur_col = 0;
          cur_row = 0;
          load_cursor();
        end
        ttw_pkg::CH_CR: cur_col = 0;
        ttw_pkg::CH_DEL: begin
          lin = cur_row * NCOLS + cur_col;
          if (lin < NCELLS) screen_cells[lin] = blank_word;
        end
        default: begin
          if (cur_col >= NCOLS) new_line();
          screen_cells[cur_row * NCOLS + cur_col] = {attr_byte, w.char_code};
          cur_col++;
        end
      endcase
      if (w.end_of_write) load_cursor();
    end
    r.cursor_offset = cursor_reg;
    return r;
  endfunction

  always @(posedge clk) begin
    ttw_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        e = expected_results.pop_front();
        if (e.cursor_offset !== out_item.cursor_offset || e.cell_data !== out_item.cell_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cursor %0d data %h, got cursor %0d data %h",
                     e.cursor_offset, e.cell_data, out_item.cursor_offset, out_item.cell_data);
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall;
    int calm;
    bit held;
    stall = 0;
    calm = 0;
    held = 0;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 100) begin
        out_ready = 0;
        repeat (600) @(negedge clk);
        held = 1;
      end
      if (stall > 0) begin
        out_ready = 0;
        stall--;
      end else begin
        out_ready = 1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 63) == 0) calm = $urandom_range(20, 200);
        else if ($urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
      end
      @(negedge clk);
    end
  end

  int burst_left = 0;

  task automatic send_word(ttw_pkg::in_item_t w, bit fixed = 0,
                           ttw_pkg::out_item_t fixed_res = '0);
    ttw_pkg::out_item_t p;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_item = w;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    p = predict_terminal(w);
    expected_results.push_back(fixed ? fixed_res : p);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(ttw_pkg::cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ttw_pkg::CFG_CHAR_ATTRIBUTE) attr_byte = val[7:0];
    else blank_word = val;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic void add_row(bit fx, bit f, logic [7:0] c, bit eow,
                                  logic [10:0] idx, logic [10:0] cur = 0,
                                  logic [15:0] dat = 0);
    dir_row_t r;
    r.fixed = fx;
    r.word = '{func: f, char_code: c, end_of_write: eow, cell_index: idx};
    r.result = '{cursor_offset: cur, cell_data: dat};
    directed_rows.push_back(r);
  endfunction

  function automatic bit is_control(logic [7:0] c);
    return c inside {ttw_pkg::CH_NUL, ttw_pkg::CH_ENQ, ttw_pkg::CH_BEL, ttw_pkg::CH_BS,
                     ttw_pkg::CH_HT, ttw_pkg::CH_LF, ttw_pkg::CH_VT, ttw_pkg::CH_FF,
                     ttw_pkg::CH_CR, ttw_pkg::CH_DEL};
  endfunction

  task automatic run_random(int count);
    int print_run;
    int r;
    ttw_pkg::in_item_t w;
    logic [7:0] ctl [10];
    ctl = '{ttw_pkg::CH_NUL, ttw_pkg::CH_ENQ, ttw_pkg::CH_BEL, ttw_pkg::CH_BS,
            ttw_pkg::CH_HT, ttw_pkg::CH_CR, ttw_pkg::CH_DEL, ttw_pkg::CH_LF,
            ttw_pkg::CH_VT, ttw_pkg::CH_FF};
    print_run = 0;
    for (int n = 0; n < count; n++) begin
      w.func = 0;
      w.end_of_write = ($urandom_range(0, 3) == 0);
      w.cell_index = 11'($urandom_range(0, 2047));
      w.char_code = 8'($urandom_range(0, 255));
      if (print_run > 0) begin
        while (is_control(w.char_code)) w.char_code = 8'($urandom_range(0, 255));
        print_run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          print_run = ($urandom_range(0, 1) == 0) ? $urandom_range(74, 82) : $urandom_range(1, 20);
          while (is_control(w.char_code)) w.char_code = 8'($urandom_range(0, 255));
        end else if (r < 45) begin
          w.func = 1;
          if ($urandom_range(0, 4) != 0) w.cell_index = 11'($urandom_range(0, NCELLS - 1));
        end else if (r < 80) begin
          w.char_code = ctl[$urandom_range(0, 6)];
        end else if (r < 88) begin
          w.char_code = ctl[$urandom_range(7, 8)];
        end else if (r < 90) begin
          w.char_code = ttw_pkg::CH_FF;
        end
      end
      send_word(w);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_item = '0;
    cfg_valid = 0;
    cfg_index = ttw_pkg::CFG_CHAR_ATTRIBUTE;
    cfg_data = '0;
    attr_byte = ttw_pkg::ATTR_RESET;
    blank_word = ttw_pkg::BLANK_RESET;
    foreach (screen_cells[i]) screen_cells[i] = ttw_pkg::BLANK_RESET;
    cur_col = 0;
    cur_row = 0;
    cursor_reg = '0;

    add_row(1, 1, 0, 0, 0, 0, 16'h0720);
    add_row(1, 1, 0, 0, 1999, 0, 16'h0720);
    add_row(1, 1, 0, 0, 2047, 0, 16'h0000);
    add_row(1, 1, 0, 0, 2000, 0, 16'h0000);
    add_row(1, 0, 8'h41, 0, 0, 0, 0);
    add_row(1, 0, 8'hFF, 1, 0, 2, 0);
    add_row(1, 1, 0, 0, 0, 2, 16'h0741);
    add_row(1, 1, 0, 0, 1, 2, 16'h07FF);
    add_row(1, 0, ttw_pkg::CH_NUL, 1, 0, 2, 0);
    add_row(0, 0, ttw_pkg::CH_ENQ, 0, 0);
    add_row(0, 0, ttw_pkg::CH_BEL, 0, 0);
    add_row(1, 0, ttw_pkg::CH_BS, 1, 0, 1, 0);
    add_row(1, 1, 0, 0, 1, 1, 16'h0720);
    add_row(1, 0, ttw_pkg::CH_HT, 1, 0, 8, 0);
    add_row(0, 0, ttw_pkg::CH_DEL, 0, 0);
    add_row(1, 0, ttw_pkg::CH_CR, 1, 0, 0, 0);
    add_row(1, 0, ttw_pkg::CH_LF, 1, 0, 80, 0);
    add_row(1, 0, ttw_pkg::CH_VT, 1, 0, 160, 0);
    add_row(0, 0, 8'h80, 0, 0);
    add_row(1, 0, ttw_pkg::CH_FF, 0, 0, 0, 0);
    add_row(1, 1, 0, 0, 160, 0, 16'h0720);
    add_row(1, 0, 8'h20, 1, 2047, 1, 0);
    add_row(1, 1, 0, 1, 0, 1, 16'h0720);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);
    run_random(330);
    drain();
    write_reg(ttw_pkg::CFG_CHAR_ATTRIBUTE, 16'h0000);
    write_reg(ttw_pkg::CFG_BLANK_CELL, 16'h0000);
    run_random(330);
    drain();
    write_reg(ttw_pkg::CFG_CHAR_ATTRIBUTE, 16'h00FF);
    write_reg(ttw_pkg::CFG_BLANK_CELL, 16'hFFFF);
    run_random(330);
    for (int k = 0; k < 2; k++) begin
      drain();
      write_reg(ttw_pkg::CFG_CHAR_ATTRIBUTE, 16'($urandom_range(0, 255)));
      write_reg(ttw_pkg::CFG_BLANK_CELL, 16'($urandom_range(0, 65535)));
      run_random(330);
    end
    drain();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/ttw_pkg.sv
design/ttw_ram.sv
design/ttw_front.sv
design/ttw_back.sv
design/text_mode_terminal_writer.sv
design/ttw_checker.sv
sim/tb_top.sv
